>>> rtl/ptld_pkg.sv
// Shared constants for the point-to-line distance pipeline.
package ptld_pkg;

  // Default coordinate width and the fixed result geometry.
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned DIST_W          = 17;
  // Root bits resolved by the cell chain: one overflow bit above the result.
  localparam int unsigned ROOT_W          = DIST_W + 1;
  localparam int unsigned OUT_TDATA_W     = ((DIST_W + 7) / 8) * 8;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

>>> rtl/ptld_cell.sv
// One root-digit cell: resolves a single bit of the floored distance.
module ptld_cell #(
  parameter int unsigned AW  = 73,
  parameter int unsigned DNW = 35,
  parameter int unsigned BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [AW-1:0]               rem_i,
  input  logic [AW-1:0]               prod_i,
  input  logic [DNW-1:0]              den_i,
  input  logic [ptld_pkg::ROOT_W-1:0] root_i,
  input  logic                        degen_i,
  output logic                        valid_o,
  output logic [AW-1:0]               rem_o,
  output logic [AW-1:0]               prod_o,
  output logic [DNW-1:0]              den_o,
  output logic [ptld_pkg::ROOT_W-1:0] root_o,
  output logic                        degen_o
);
  import ptld_pkg::*;

  logic [AW-1:0]     den_ext;
  logic [AW-1:0]     delta;
  logic [AW:0]       diff;
  logic              take;
  logic              valid_q;
  logic [AW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     prod_q, prod_d;
  logic [DNW-1:0]    den_q;
  logic [ROOT_W-1:0] root_q, root_d;
  logic              degen_q;

  // (d + 2^b)^2 * den - d^2 * den = (d*den) << (b+1) + den << 2b
  assign den_ext = AW'(den_i);
  assign delta   = (prod_i << (BIT + 1)) + (den_ext << (2 * BIT));
  assign diff    = {1'b0, rem_i} - {1'b0, delta};
  assign take    = ~diff[AW];

  always_comb begin
    rem_d  = rem_i;
    prod_d = prod_i;
    root_d = root_i;
    if (take) begin
      rem_d       = diff[AW-1:0];
      prod_d      = prod_i + (den_ext << BIT);
      root_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      prod_q  <= prod_d;
      den_q   <= den_i;
      root_q  <= root_d;
      degen_q <= degen_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign prod_o  = prod_q;
  assign den_o   = den_q;
  assign root_o  = root_q;
  assign degen_o = degen_q;

endmodule

>>> rtl/point_to_line_distance.sv
// Top level: streaming point-to-line distance with a chain of root-digit cells.
// Pipeline: 5 front stages, 18 cells and 1 output register.
// Throughput: one beat per cycle; every stage advances together and the whole
// pipeline holds while the output beat is valid and not taken.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers
// are not reset. No other state is kept between beats.
module point_to_line_distance #(
  parameter int unsigned COORD_WIDTH = ptld_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: point_x, point_y, start_x, start_y, end_x, end_y (COORD_WIDTH each),
  // zero fill to whole bytes
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  // tdata: distance (17 bits), zero fill; tuser: degenerate
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [ptld_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic                                    m_axis_tuser_o
);
  import ptld_pkg::*;

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned DW    = W + 1;          // coordinate differences
  localparam int unsigned PW    = 2 * W + 2;      // signed products
  localparam int unsigned L2W   = 2 * W + 3;      // squared lengths
  localparam int unsigned CW    = 2 * W + 4;      // cross product and magnitude
  localparam int unsigned LO_W  = W + 2;
  localparam int unsigned HI_W  = CW - LO_W;
  localparam int unsigned NUM_W = 2 * CW;
  localparam int unsigned AW    = ((NUM_W > L2W + 37) ? NUM_W : L2W + 37) + 1;

  // Advance every stage unless the output beat is stuck.
  logic en;
  logic out_valid_q;
  assign en              = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: differences u = E - S, v = P - S.
  logic signed [W-1:0]  px, py, sx, sy, ex, ey;
  logic                 v1_q;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q;

  assign px = s_axis_tdata_i[0*W +: W];
  assign py = s_axis_tdata_i[1*W +: W];
  assign sx = s_axis_tdata_i[2*W +: W];
  assign sy = s_axis_tdata_i[3*W +: W];
  assign ex = s_axis_tdata_i[4*W +: W];
  assign ey = s_axis_tdata_i[5*W +: W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= DW'(ex) - DW'(sx);
      uy_q <= DW'(ey) - DW'(sy);
      vx_q <= DW'(px) - DW'(sx);
      vy_q <= DW'(py) - DW'(sy);
    end
  end

  // Stage 2: the six products.
  logic                 v2_q;
  logic signed [PW-1:0] uxux_q, uyuy_q, uxvy_q, uyvx_q, vxvx_q, vyvy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      uxux_q <= PW'(ux_q) * PW'(ux_q);
      uyuy_q <= PW'(uy_q) * PW'(uy_q);
      uxvy_q <= PW'(ux_q) * PW'(vy_q);
      uyvx_q <= PW'(uy_q) * PW'(vx_q);
      vxvx_q <= PW'(vx_q) * PW'(vx_q);
      vyvy_q <= PW'(vy_q) * PW'(vy_q);
    end
  end

  // Stage 3: squared line length, |cross product|, squared point offset.
  logic                 v3_q;
  logic [L2W-1:0]       l2_q, vv_q;
  logic [CW-1:0]        cmag_q;
  logic                 degen3_q;
  logic signed [CW-1:0] cross_prod;
  logic [L2W-1:0]       l2_sum;

  assign cross_prod = CW'(uxvy_q) - CW'(uyvx_q);
  assign l2_sum     = L2W'(uxux_q) + L2W'(uyuy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_q     <= l2_sum;
      vv_q     <= L2W'(vxvx_q) + L2W'(vyvy_q);
      cmag_q   <= cross_prod[CW-1] ? CW'(-cross_prod) : CW'(cross_prod);
      degen3_q <= (l2_sum == '0);
    end
  end

  // Stage 4: square the cross magnitude as three partial products.
  logic                    v4_q;
  logic [2*HI_W-1:0]       hh_q;
  logic [HI_W+LO_W-1:0]    hl_q;
  logic [2*LO_W-1:0]       ll_q;
  logic [L2W-1:0]          den4_q, vv4_q;
  logic                    degen4_q;
  logic [HI_W-1:0]         c_hi;
  logic [LO_W-1:0]         c_lo;

  assign c_hi = cmag_q[CW-1:LO_W];
  assign c_lo = cmag_q[LO_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q     <= (2*HI_W)'(c_hi) * (2*HI_W)'(c_hi);
      hl_q     <= (HI_W+LO_W)'(c_hi) * (HI_W+LO_W)'(c_lo);
      ll_q     <= (2*LO_W)'(c_lo) * (2*LO_W)'(c_lo);
      den4_q   <= degen3_q ? L2W'(1) : l2_q;
      vv4_q    <= vv_q;
      degen4_q <= degen3_q;
    end
  end

  // Stage 5: numerator of the root test, C^2 or |P-S|^2 with a unit divisor.
  logic              v5_q;
  logic [NUM_W-1:0]  num_q;
  logic [L2W-1:0]    den5_q;
  logic              degen5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q    <= degen4_q ? NUM_W'(vv4_q)
                           : (NUM_W'(hh_q) << (2 * LO_W)) + (NUM_W'(hl_q) << (LO_W + 1))
                             + NUM_W'(ll_q);
      den5_q   <= den4_q;
      degen5_q <= degen4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Cell chain: cell k resolves root bit ROOT_W-1-k, top bit flags overflow.
  logic                 c_valid [0:ROOT_W];
  logic [AW-1:0]        c_rem   [0:ROOT_W];
  logic [AW-1:0]        c_prod  [0:ROOT_W];
  logic [L2W-1:0]       c_den   [0:ROOT_W];
  logic [ROOT_W-1:0]    c_root  [0:ROOT_W];
  logic                 c_degen [0:ROOT_W];

  assign c_valid[0] = v5_q;
  assign c_rem[0]   = AW'(num_q);
  assign c_prod[0]  = '0;
  assign c_den[0]   = den5_q;
  assign c_root[0]  = '0;
  assign c_degen[0] = degen5_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    ptld_cell #(
      .AW  (AW),
      .DNW (L2W),
      .BIT (ROOT_W - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[k]),
      .rem_i   (c_rem[k]),
      .prod_i  (c_prod[k]),
      .den_i   (c_den[k]),
      .root_i  (c_root[k]),
      .degen_i (c_degen[k]),
      .valid_o (c_valid[k+1]),
      .rem_o   (c_rem[k+1]),
      .prod_o  (c_prod[k+1]),
      .den_o   (c_den[k+1]),
      .root_o  (c_root[k+1]),
      .degen_o (c_degen[k+1])
    );
  end

  // Output register: saturate when the overflow bit is set.
  logic [DIST_W-1:0] dist_q;
  logic              degen_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q      <= c_root[ROOT_W][ROOT_W-1] ? DIST_MAX : c_root[ROOT_W][DIST_W-1:0];
      degen_out_q <= c_degen[ROOT_W];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(dist_q);
  assign m_axis_tuser_o  = degen_out_q;

endmodule

>>> verif/point_to_line_distance_tb.sv
// Self-checking stream testbench for the point-to-line distance pipeline.
`timescale 1ns / 1ps

module point_to_line_distance_tb;

  localparam int unsigned CW       = ptld_pkg::COORD_WIDTH_DEF;
  localparam int unsigned IN_W     = ((6 * CW + 7) / 8) * 8;
  localparam int unsigned DW       = ptld_pkg::DIST_W;
  localparam int unsigned N_RANDOM = 1500;
  localparam int unsigned LIMIT    = 400000;
  localparam int unsigned DRAIN    = 40;    // drain margin beyond the pipeline depth
  localparam int unsigned HOLD_AT  = 300;   // result count that starts the long hold-off
  localparam int unsigned HOLD_LEN = 250;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic          degenerate;
  } dist_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [ptld_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic            m_axis_tuser_o;

  logic [IN_W-1:0] pending_beats[$];
  dist_result_t    expected_dists[$];
  int unsigned     sent_cnt = 0, recv_cnt = 0, degen_cnt = 0, err_cnt = 0;
  int unsigned     cycle_cnt = 0;
  int unsigned     send_gap = 0, recv_gap = 0, hold_cnt = 0;
  bit              hold_done = 1'b0;

  point_to_line_distance dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // px, py, sx, sy, ex, ey from bit 0 up
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // distance, zero fill from bit 0 up
    .m_axis_tuser_o (m_axis_tuser_o)    // degenerate
  );

  always #10 clk_i = ~clk_i;

  // Exact floor(|C| / sqrt(L2)) by a bitwise root search, or the floored point-to-start
  // length when both line points coincide. Wide vectors keep every product exact.
  function automatic dist_result_t predict_distance(input logic [IN_W-1:0] beat);
    longint       px, py, sx, sy, ex, ey, ux, uy, vx, vy, cprod;
    logic [127:0] num, den, trial, acc;
    dist_result_t r;
    px = longint'($signed(beat[0*CW +: CW]));
    py = longint'($signed(beat[1*CW +: CW]));
    sx = longint'($signed(beat[2*CW +: CW]));
    sy = longint'($signed(beat[3*CW +: CW]));
    ex = longint'($signed(beat[4*CW +: CW]));
    ey = longint'($signed(beat[5*CW +: CW]));
    ux = ex - sx; uy = ey - sy; vx = px - sx; vy = py - sy;
    den = 128'(ux * ux) + 128'(uy * uy);
    r.degenerate = (den == 0);
    if (r.degenerate) begin
      num = 128'(vx * vx) + 128'(vy * vy);
      den = 128'd1;
    end else begin
      cprod = ux * vy - uy * vx;
      if (cprod < 0) cprod = -cprod;
      num = 128'(cprod) * 128'(cprod);
    end
    acc = '0;
    for (int b = 36; b >= 0; b--) begin
      trial = acc | (128'd1 << b);
      if (trial * trial * den <= num) acc = trial;
    end
    r.distance = (acc > 128'(ptld_pkg::DIST_MAX)) ? ptld_pkg::DIST_MAX : acc[DW-1:0];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_beat(input logic [CW-1:0] px, py, sx, sy, ex, ey);
    return IN_W'({ey, ex, sy, sx, py, px});
  endfunction

  function automatic logic [CW-1:0] corner_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return '0;
      3: return CW'(1);
      4: return '1;
      default: return CW'($urandom_range(0, 15)) - CW'(8);
    endcase
  endfunction

  // Driver: advance to the next pending beat once the current one is taken,
  // after a random gap; in every third run of 150 sent beats hold no gaps at all.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_dists.push_back(predict_distance(s_axis_tdata_i));
        sent_cnt++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_beats.pop_front();
          send_gap = ((sent_cnt / 150) % 3 == 1) ? 0 : $urandom_range(0, 13);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result beat against the oldest prediction, then
  // draw the stall before the next one; once, hold off long enough to back up
  // the whole pipeline while the driver keeps offering beats.
  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        recv_cnt++;
        if (expected_dists.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, actual distance=%0d degenerate=%0b",
                   $time, m_axis_tdata_o[DW-1:0], m_axis_tuser_o);
        end else begin
          want = expected_dists.pop_front();
          if (want.degenerate) degen_cnt++;
          if (m_axis_tdata_o[DW-1:0] !== want.distance) begin
            err_cnt++;
            $display("%0t: distance mismatch, expected=%0d actual=%0d",
                     $time, want.distance, m_axis_tdata_o[DW-1:0]);
          end
          if (m_axis_tuser_o !== want.degenerate) begin
            err_cnt++;
            $display("%0t: degenerate mismatch, expected=%0b actual=%0b",
                     $time, want.degenerate, m_axis_tuser_o);
          end
          if (m_axis_tdata_o[ptld_pkg::OUT_TDATA_W-1:DW] !== '0) begin
            err_cnt++;
            $display("%0t: tdata fill mismatch, expected=0 actual=%0h",
                     $time, m_axis_tdata_o[ptld_pkg::OUT_TDATA_W-1:DW]);
          end
        end
        recv_gap = ((recv_cnt / 120) % 3 == 2) ? 0 : $urandom_range(0, 13);
        if (!hold_done && recv_cnt == HOLD_AT) begin
          hold_done = 1'b1;
          hold_cnt  = HOLD_LEN;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: bound the run in clock cycles.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CW-1:0] px, py, sx, sy, ex, ey;
    logic [CW-1:0] cmin, cmax;
    int unsigned   kind;
    cmin = {1'b1, {(CW-1){1'b0}}};
    cmax = {1'b0, {(CW-1){1'b1}}};

    // Directed: coincident line points, extremes, axis-aligned lines, point on line.
    pending_beats.push_back(pack_beat('0, '0, '0, '0, '0, '0));
    pending_beats.push_back(pack_beat(cmax, cmax, cmin, cmin, cmin, cmin));
    pending_beats.push_back(pack_beat(cmin, cmin, cmax, cmax, cmax, cmax));
    pending_beats.push_back(pack_beat(cmax, cmin, cmin, cmax, cmin, cmax));
    pending_beats.push_back(pack_beat(cmax, cmin, cmin, cmin, cmax, cmax));
    pending_beats.push_back(pack_beat(cmin, cmax, cmin, cmin, cmax, cmax));
    pending_beats.push_back(pack_beat(cmax, cmax, cmin, cmin, cmax, cmin));
    pending_beats.push_back(pack_beat(cmin, cmax, cmin, cmin, cmin, cmax + CW'(0)));
    pending_beats.push_back(pack_beat(cmax, cmin, cmin, cmax, cmax, cmax));
    pending_beats.push_back(pack_beat(CW'(5), CW'(5), '0, '0, CW'(9), CW'(9)));
    pending_beats.push_back(pack_beat(CW'(3), CW'(4), '0, '0, CW'(1), '0));
    pending_beats.push_back(pack_beat(CW'(7), '1, '0, '0, '0, CW'(1)));
    pending_beats.push_back(pack_beat(CW'(1), CW'(1), '0, '0, CW'(1), CW'(2)));
    pending_beats.push_back(pack_beat('1, '1, '0, '0, '0, '0));
    pending_beats.push_back(pack_beat(CW'(3), CW'(4), '0, '0, '0, '0));
    pending_beats.push_back(pack_beat('0, '0, cmax, cmin, cmax, cmin));
    pending_beats.push_back(pack_beat(cmin, cmin, cmax, cmax, cmax - CW'(1), cmax));
    pending_beats.push_back(pack_beat(cmax, cmax, cmin, cmin, cmin + CW'(1), cmin));

    // Random: mostly full-range lines, plus coincident points, corner values and
    // short lines that make the division coarse.
    repeat (N_RANDOM) begin
      kind = $urandom_range(0, 9);
      px = CW'($urandom); py = CW'($urandom);
      sx = CW'($urandom); sy = CW'($urandom);
      ex = CW'($urandom); ey = CW'($urandom);
      if (kind == 0) begin
        ex = sx; ey = sy;
      end else if (kind == 1) begin
        px = corner_coord(); py = corner_coord(); sx = corner_coord();
        sy = corner_coord(); ex = corner_coord(); ey = corner_coord();
      end else if (kind == 2) begin
        ex = sx + CW'($urandom_range(0, 6)) - CW'(3);
        ey = sy + CW'($urandom_range(0, 6)) - CW'(3);
      end
      pending_beats.push_back(pack_beat(px, py, sx, sy, ex, ey));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_beats.size() == 0 && !s_axis_tvalid_i && expected_dists.size() == 0);
    repeat (DRAIN) @(posedge clk_i);

    $display("Covered %0d beats (%0d with coincident line points), one result each;",
             sent_cnt, degen_cnt);
    $display("random gaps on both sides plus one long output hold-off.");
    if (err_cnt == 0 && expected_dists.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ptld_pkg.sv
rtl/ptld_cell.sv
rtl/point_to_line_distance.sv
verif/point_to_line_distance_tb.sv
